### design/brlr_pkg.sv
// Shared types, codes and constants for the byte ring with lookahead read.
package brlr_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int MAX_MSG_C = 256;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_WBYTE = 2'd1;
    localparam logic [1:0] OP_RBYTE = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [8:0] message_length;
        logic [7:0] write_data;
        logic       from_lookahead;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic       write_granted;
        logic       byte_stored;
        logic [9:0] readable_count;
        logic [9:0] lookahead_count;
        logic [9:0] free_space;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic publish;
    } cmd_t;

endpackage

### design/brlr_ctrl.sv
// Controller state machine: input and output handshakes and datapath commands.
module brlr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output brlr_pkg::cmd_t cmd
);
    import brlr_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                // load the output register once the previous result has left
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    a_exec_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> (state_reg == ST_FINISH))
        else $error("execute step not followed by finish");

    a_rise_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result appeared outside finish");

    a_publish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while stalled");

endmodule

### design/brlr_dp.sv
// Datapath: byte storage, ring pointers, item and result registers.
module brlr_dp #(
    parameter int DEPTH = brlr_pkg::DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  brlr_pkg::cmd_t      cmd,
    input  brlr_pkg::in_item_t  in_item,
    output brlr_pkg::out_item_t out_item
);
    import brlr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

    logic [7:0] mem [DEPTH];

    in_item_t  item_reg;
    out_item_t out_reg;
    logic [AW-1:0] commit_ptr_reg, pend_ptr_reg, rd_ptr_reg, peek_ptr_reg;
    logic [AW-1:0] commit_ptr_next, pend_ptr_next, rd_ptr_next, peek_ptr_next;
    logic [8:0]    remain_reg, remain_next;
    logic          rvalid_reg, grant_reg, stored_reg;
    logic          rvalid_next, grant_next, stored_next;
    logic [7:0]    rdata_reg;

    logic [AW-1:0] sel_ptr;
    logic [CW-1:0] q_sel, q_rd, q_peek, room;
    logic          can_read, grant_ok, do_write;

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
        return (p == LAST_C) ? '0 : p + AW'(1);
    endfunction

    // committed bytes between position p and the commit pointer
    function automatic logic [CW-1:0] behind(input logic [AW-1:0] c,
                                             input logic [AW-1:0] p);
        logic [CW-1:0] d;
        d = {1'b0, c} - {1'b0, p};
        return (c >= p) ? d : d + DEPTH_C;
    endfunction

    function automatic logic [9:0] low10(input logic [CW-1:0] v);
        logic [CW+9:0] t;
        t = (CW+10)'(v);
        return t[9:0];
    endfunction

    assign sel_ptr  = item_reg.from_lookahead ? peek_ptr_reg : rd_ptr_reg;
    assign q_sel    = behind(commit_ptr_reg, sel_ptr);
    assign q_rd     = behind(commit_ptr_reg, rd_ptr_reg);
    assign q_peek   = behind(commit_ptr_reg, peek_ptr_reg);
    assign room     = DEPTH_C - CW'(1) - q_rd;
    assign can_read = (q_sel != '0);
    assign grant_ok = (32'(item_reg.message_length) <= 32'(room))
                   && (32'(item_reg.message_length) <= 32'(MAX_MSG_C));
    assign do_write = cmd.execute && (item_reg.operation == OP_WBYTE)
                   && (remain_reg != '0);

    always_comb
    begin
        commit_ptr_next = commit_ptr_reg;
        pend_ptr_next   = pend_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        peek_ptr_next   = peek_ptr_reg;
        remain_next     = remain_reg;
        rvalid_next     = rvalid_reg;
        grant_next      = grant_reg;
        stored_next     = stored_reg;
        if (cmd.execute)
        begin
            rvalid_next = 1'b0;
            grant_next  = 1'b0;
            stored_next = 1'b0;
            unique case (item_reg.operation)
                OP_START:
                begin
                    // drop any open message and restart at the commit point
                    pend_ptr_next = commit_ptr_reg;
                    grant_next    = grant_ok;
                    remain_next   = grant_ok ? item_reg.message_length : '0;
                end
                OP_WBYTE:
                begin
                    if (remain_reg != '0)
                    begin
                        pend_ptr_next = advance(pend_ptr_reg);
                        remain_next   = remain_reg - 9'd1;
                        stored_next   = 1'b1;
                        if (remain_reg == 9'd1)
                        begin
                            commit_ptr_next = advance(pend_ptr_reg);
                        end
                    end
                end
                OP_RBYTE:
                begin
                    if (can_read)
                    begin
                        rvalid_next   = 1'b1;
                        peek_ptr_next = advance(sel_ptr);
                        if (!item_reg.from_lookahead)
                        begin
                            rd_ptr_next = advance(sel_ptr);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            commit_ptr_reg <= '0;
            pend_ptr_reg   <= '0;
            rd_ptr_reg     <= '0;
            peek_ptr_reg   <= '0;
            remain_reg     <= '0;
            rvalid_reg     <= 1'b0;
            grant_reg      <= 1'b0;
            stored_reg     <= 1'b0;
        end
        else
        begin
            commit_ptr_reg <= commit_ptr_next;
            pend_ptr_reg   <= pend_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            peek_ptr_reg   <= peek_ptr_next;
            remain_reg     <= remain_next;
            rvalid_reg     <= rvalid_next;
            grant_reg      <= grant_next;
            stored_reg     <= stored_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[pend_ptr_reg] <= item_reg.write_data;
        end
        if (cmd.execute)
        begin
            rdata_reg <= mem[sel_ptr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
        if (cmd.publish)
        begin
            out_reg.read_data       <= rvalid_reg ? rdata_reg : 8'd0;
            out_reg.read_valid      <= rvalid_reg;
            out_reg.write_granted   <= grant_reg;
            out_reg.byte_stored     <= stored_reg;
            out_reg.readable_count  <= low10(q_rd);
            out_reg.lookahead_count <= low10(q_peek);
            out_reg.free_space      <= low10(room);
        end
    end

    assign out_item = out_reg;

    a_peek_not_behind: assert property (@(posedge clk) disable iff (!rst_n)
        q_peek <= q_rd)
        else $error("lookahead pointer fell behind the read pointer");

    a_remain_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(remain_reg) <= 32'(MAX_MSG_C))
        else $error("open message longer than allowed");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(commit_ptr_reg) < 32'(DEPTH)) && (32'(pend_ptr_reg) < 32'(DEPTH)))
        else $error("write pointer out of range");

endmodule

### design/byte_ring_with_lookahead_read_top.sv
// Top level of the byte ring buffer with a lookahead read pointer.
// A result follows the execute and finish states; out_stall can hold finish.
// One item at a time: capture, execute (a storage write for byte writes and a
//   registered storage read) and publish run in turn under the controller.
// Reset (rst_n low, asynchronous): all pointers and the open-message count go to zero.
// Storage is not cleared; only written slots are ever read, so no clearing pass runs.
module byte_ring_with_lookahead_read_top #(
    parameter int DEPTH = brlr_pkg::DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  brlr_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output brlr_pkg::out_item_t out_item
);
    import brlr_pkg::*;

    // Commands from the controller to the datapath.
    cmd_t cmd;

    // Controller: hold off new transfers while an item is at work, and load the
    // output register only when the previous result transfer is done.
    brlr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Datapath: ring storage, commit/pending/read/lookahead pointers and the
    // registered result with the three occupancy counts.
    brlr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_item  (in_item),
        .out_item (out_item)
    );

endmodule
